[rtl/efas_pkg.sv]
// Shared constants and request codes for the Elias-Fano access and search block.
package efas_pkg;

  localparam int IMG_AW      = 16;   // image byte address bits
  localparam int IDX_W       = 20;   // element index bits in results
  localparam int RNG_W       = 21;   // search range bounds
  localparam int VAL_W       = 64;   // decoded element width
  localparam int REQ_W       = 3;
  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 152;

  localparam logic [15:0] QUANTUM_RST = 16'd256;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ACCESS = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PAIR   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PREFIX = 3'd4;

endpackage

[rtl/elias_fano_access_and_search_top.sv]
// Elias-Fano image store with element access and binary search, shared-unit sequencer.
//
//  channel | dir | handshake                   | payload
//  --------+-----+-----------------------------+------------------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready | tuser: req_type; tdata: request fields
//  m_axis  | out | m_axis_tvalid/m_axis_tready | tuser: found; tdata: values, position
//  cfg     | in  | cfg_valid_i/cfg_ready_o     | cfg_data_i: select sampling interval
//
// Sequence: a load writes one image byte. One element decode reads the header, divides
// the count by the sampling interval (only when high bits exist), runs the multiplies
// and reads the low bits, then walks the high-bit bytes when high bits exist; an index
// at or past the sampling interval also adds a divide and a select-word read. A search
// costs about log2(range) decodes plus a range check per probe. The image memory, read
// one byte per cycle, and the bit-serial divider set these costs.
// Reset: rst_ni low clears the sequencer, the output register and the sampling interval
// (256); the image keeps no reset and reads are defined only for bytes written before.
// Stalls: input is taken only in the idle state; a finished word waits in the output
// register while m_axis_tready is low, and the sequencer holds until it drains.
module elias_fano_access_and_search_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] byte_address, [23:16] byte_data, [43:24] index, [64:44] range_start,
  // [85:65] range_end, [149:86] target_value, [151:150] zero
  input  logic [efas_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [2:0] req_type
  input  logic [efas_pkg::REQ_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [63:0] value_first, [127:64] value_second, [147:128] position, [151:148] zero
  output logic [efas_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] found
  output logic                               m_axis_tuser,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [15:0]                        cfg_data_i
);
  import efas_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_HDR, S_NSEL, S_DIV, S_MUL1, S_MUL2, S_LOW, S_LOWX,
    S_SEL, S_SELX, S_WALK, S_JOIN, S_RET, S_CHK, S_DONE
  } state_e;

  state_e state_q;

  // image memory, one write and one registered read per cycle
  logic [7:0]        mem_q [2**IMG_AW];
  logic [7:0]        mem_rd_q;
  logic [IMG_AW-1:0] rd_addr;
  logic              load_we;

  logic [15:0]       quantum_q;
  logic [REQ_W-1:0]  op_q;
  logic              ph_q;
  logic [RNG_W-1:0]  idx_q, lo_q, hi_q;
  logic [VAL_W-1:0]  target_q;
  logic [VAL_W-1:0]  res_first_q, res_second_q;
  logic [IDX_W-1:0]  res_pos_q;
  logic              res_found_q;

  logic [3:0]        bc_q;
  logic [63:0]       hdr_q;
  logic [IMG_AW-1:0] base_q;
  logic [47:0]       mul_q;
  logic [18:0]       lbit_q;
  logic [71:0]       buf_q;
  logic [63:0]       low_q;
  logic [IMG_AW-1:0] hbyte_q;
  logic [IMG_AW-1:0] selb_q;
  logic [31:0]       sw_q;
  logic [7:0]        mask_q;
  logic [RNG_W-1:0]  hpos_q;
  logic [63:0]       high_q;
  logic              prime_q;
  logic [15:0]       wcnt_q;
  logic [63:0]       val_q;

  // shared divider
  logic [31:0]       dvd_q;
  logic [16:0]       rem_q;
  logic [16:0]       div_d_q;
  logic [4:0]        dcnt_q;
  logic              div_tgt_q;

  function automatic logic [3:0] ones8(input logic [7:0] b);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) c = c + {3'd0, b[i]};
    return c;
  endfunction

  // zeros in front of the n-th set bit (n from 0)
  function automatic logic [3:0] zeros_before(input logic [7:0] b, input logic [2:0] n);
    logic [3:0] z;
    logic [2:0] k;
    logic       stop;
    z = 4'd0;
    k = n;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!stop) begin
        if (b[i]) begin
          if (k == 3'd0) stop = 1'b1;
          else k = k - 3'd1;
        end else begin
          z = z + 4'd1;
        end
      end
    end
    return z;
  endfunction

  logic [31:0] cnt_w;
  logic [15:0] lb_w, hb_w;
  logic [16:0] q_eff;
  logic [31:0] mul_a;
  logic [47:0] mul_p;
  logic [17:0] div_r;
  logic        div_ge;
  logic [16:0] div_rn;
  logic [31:0] div_qn, div_qm1;
  logic [71:0] low_sh;
  logic [63:0] low_mask, low_val;
  logic [7:0]  wb;
  logic [3:0]  wc, wz;
  logic        w_hit;
  logic [63:0] join_v;
  logic [21:0] mid_sum;
  logic [RNG_W-1:0] q_mult;
  logic        in_acc, out_free;
  logic        pre_first;

  assign cnt_w = hdr_q[31:0];
  assign lb_w  = hdr_q[47:32];
  assign hb_w  = hdr_q[63:48];
  assign q_eff = (quantum_q == 16'd0) ? 17'h10000 : {1'b0, quantum_q};

  // one multiplier: idx*lb for the low-bit address, then count*lb for the high array base
  assign mul_a = (state_q == S_MUL1) ? {11'd0, idx_q} : cnt_w;
  assign mul_p = {16'd0, mul_a} * {32'd0, lb_w};

  assign div_r   = {rem_q, dvd_q[31]};
  assign div_ge  = div_r >= {1'b0, div_d_q};
  assign div_rn  = div_ge ? 17'(div_r - {1'b0, div_d_q}) : div_r[16:0];
  assign div_qn  = {dvd_q[30:0], div_ge};
  assign div_qm1 = div_qn - 32'd1;

  assign low_sh   = buf_q >> lbit_q[2:0];
  assign low_mask = (lb_w >= 16'd64) ? {64{1'b1}} : ((64'd1 << lb_w[5:0]) - 64'd1);
  assign low_val  = low_sh[63:0] & low_mask;

  assign wb    = mem_rd_q & mask_q;
  assign wc    = ones8(wb);
  assign wz    = zeros_before(wb, hpos_q[2:0]);
  assign w_hit = {17'd0, wc} > hpos_q;

  assign join_v  = ((lb_w >= 16'd64) ? 64'd0 : (high_q << lb_w[5:0])) | low_q;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign q_mult  = idx_q - {4'd0, rem_q};

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign load_we       = in_acc && (s_axis_tuser == REQ_LOAD);

  // prefix search over a nonempty range that starts above zero: decode the element
  // in front of the range first
  assign pre_first = (s_axis_tuser == REQ_PREFIX) &&
                     (s_axis_tdata[64:44] < s_axis_tdata[85:65]) &&
                     (s_axis_tdata[64:44] != '0);

  always_comb begin
    case (state_q)
      S_HDR:   rd_addr = IMG_AW'(bc_q);
      S_LOW:   rd_addr = lbit_q[18:3] + IMG_AW'(bc_q);
      S_SEL:   rd_addr = selb_q + IMG_AW'(bc_q);
      S_WALK:  rd_addr = hbyte_q;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_we) mem_q[s_axis_tdata[15:0]] <= s_axis_tdata[23:16];
    mem_rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      quantum_q     <= QUANTUM_RST;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= 1'b0;
      op_q <= '0; ph_q <= 1'b0; idx_q <= '0; lo_q <= '0; hi_q <= '0; target_q <= '0;
      res_first_q <= '0; res_second_q <= '0; res_pos_q <= '0; res_found_q <= 1'b0;
      bc_q <= '0; hdr_q <= '0; base_q <= '0; mul_q <= '0; lbit_q <= '0; buf_q <= '0;
      low_q <= '0; hbyte_q <= '0; selb_q <= '0; sw_q <= '0; mask_q <= '0; hpos_q <= '0;
      high_q <= '0; prime_q <= 1'b0; wcnt_q <= '0; val_q <= '0;
      dvd_q <= '0; rem_q <= '0; div_d_q <= 17'd1; dcnt_q <= '0; div_tgt_q <= 1'b0;
    end else begin
      if (cfg_valid_i) quantum_q <= cfg_data_i;
      // drop valid once taken, unless the finish state reloads it this cycle
      if (m_axis_tvalid && m_axis_tready && (state_q != S_DONE)) m_axis_tvalid <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q         <= s_axis_tuser;
            idx_q        <= pre_first ? s_axis_tdata[64:44] - RNG_W'(1)
                                      : {1'b0, s_axis_tdata[43:24]};
            lo_q         <= s_axis_tdata[64:44];
            hi_q         <= s_axis_tdata[85:65];
            target_q     <= s_axis_tdata[149:86];
            res_first_q  <= '0;
            res_second_q <= '0;
            res_pos_q    <= '0;
            res_found_q  <= 1'b0;
            ph_q         <= pre_first;
            bc_q         <= '0;
            case (s_axis_tuser)
              REQ_ACCESS, REQ_PAIR: state_q <= S_HDR;
              REQ_SEARCH:           state_q <= S_CHK;
              REQ_PREFIX: begin
                if (s_axis_tdata[64:44] < s_axis_tdata[85:65]) begin
                  if (pre_first) state_q <= S_HDR;
                  else state_q <= S_CHK;
                end else begin
                  state_q <= S_DONE;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end
        end

        S_HDR: begin
          if (bc_q != 4'd0) hdr_q <= {mem_rd_q, hdr_q[63:8]};
          if (bc_q == 4'd8) state_q <= S_NSEL;
          else bc_q <= bc_q + 4'd1;
        end

        S_NSEL: begin
          if (hb_w != 16'd0) begin
            dvd_q     <= cnt_w - 32'd1;
            rem_q     <= '0;
            div_d_q   <= q_eff;
            dcnt_q    <= '0;
            div_tgt_q <= 1'b0;
            state_q   <= S_DIV;
          end else begin
            base_q  <= IMG_AW'(8);
            state_q <= S_MUL1;
          end
        end

        S_DIV: begin
          dvd_q  <= div_qn;
          rem_q  <= div_rn;
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'd31) begin
            bc_q <= '0;
            if (!div_tgt_q) begin
              base_q  <= IMG_AW'(8) + {div_qn[13:0], 2'b00};
              state_q <= S_MUL1;
            end else begin
              selb_q  <= IMG_AW'(8) + {div_qm1[13:0], 2'b00};
              state_q <= S_SEL;
            end
          end
        end

        S_MUL1: begin
          mul_q   <= mul_p;
          state_q <= S_MUL2;
        end

        S_MUL2: begin
          lbit_q  <= {base_q, 3'b000} + mul_q[18:0];
          mul_q   <= mul_p;
          bc_q    <= '0;
          state_q <= S_LOW;
        end

        S_LOW: begin
          if (bc_q != 4'd0) buf_q <= {mem_rd_q, buf_q[71:8]};
          if (bc_q == 4'd9) state_q <= S_LOWX;
          else bc_q <= bc_q + 4'd1;
        end

        S_LOWX: begin
          low_q   <= low_val;
          hbyte_q <= base_q + 16'((mul_q[18:0] + 19'd7) >> 3);
          if (hb_w == 16'd0) begin
            val_q   <= low_val;
            state_q <= S_RET;
          end else if (idx_q >= RNG_W'(q_eff)) begin
            dvd_q     <= {11'd0, idx_q};
            rem_q     <= '0;
            div_d_q   <= q_eff;
            dcnt_q    <= '0;
            div_tgt_q <= 1'b1;
            state_q   <= S_DIV;
          end else begin
            hpos_q  <= idx_q;
            high_q  <= '0;
            mask_q  <= 8'hFF;
            prime_q <= 1'b1;
            wcnt_q  <= '0;
            state_q <= S_WALK;
          end
        end

        S_SEL: begin
          if (bc_q != 4'd0) sw_q <= {mem_rd_q, sw_q[31:8]};
          if (bc_q == 4'd4) state_q <= S_SELX;
          else bc_q <= bc_q + 4'd1;
        end

        S_SELX: begin
          // jump to the sampled bit and preset the high part
          hbyte_q <= hbyte_q + sw_q[18:3];
          mask_q  <= 8'hFF << sw_q[2:0];
          hpos_q  <= {4'd0, rem_q};
          high_q  <= {32'd0, sw_q[31:3], 3'b000} - {43'd0, q_mult};
          prime_q <= 1'b1;
          wcnt_q  <= '0;
          state_q <= S_WALK;
        end

        S_WALK: begin
          hbyte_q <= hbyte_q + IMG_AW'(1);
          if (prime_q) begin
            prime_q <= 1'b0;
          end else begin
            mask_q <= 8'hFF;
            wcnt_q <= wcnt_q + 16'd1;
            if (w_hit) begin
              high_q  <= high_q + {60'd0, wz};
              state_q <= S_JOIN;
            end else begin
              high_q <= high_q + {60'd0, 4'd8 - wc};
              hpos_q <= hpos_q - {17'd0, wc};
              // give up after one full pass over the image
              if (wcnt_q == 16'hFFFF) state_q <= S_JOIN;
            end
          end
        end

        S_JOIN: begin
          val_q   <= join_v;
          state_q <= S_RET;
        end

        S_RET: begin
          bc_q <= '0;
          case (op_q)
            REQ_ACCESS: begin
              res_first_q <= val_q;
              state_q     <= S_DONE;
            end
            REQ_PAIR: begin
              if (!ph_q) begin
                res_first_q <= val_q;
                idx_q       <= idx_q + RNG_W'(1);
                ph_q        <= 1'b1;
                state_q     <= S_HDR;
              end else begin
                res_second_q <= val_q;
                state_q      <= S_DONE;
              end
            end
            REQ_SEARCH, REQ_PREFIX: begin
              if (ph_q) begin
                target_q <= target_q + val_q;
                ph_q     <= 1'b0;
                state_q  <= S_CHK;
              end else if (val_q == target_q) begin
                res_found_q <= 1'b1;
                res_pos_q   <= idx_q[IDX_W-1:0];
                state_q     <= S_DONE;
              end else begin
                if (val_q > target_q) hi_q <= idx_q;
                else lo_q <= idx_q + RNG_W'(1);
                state_q <= S_CHK;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end

        S_CHK: begin
          bc_q <= '0;
          if (lo_q < hi_q) begin
            idx_q   <= mid_sum[21:1];
            state_q <= S_HDR;
          end else begin
            state_q <= S_DONE;
          end
        end

        S_DONE: begin
          // hold until the output register drains
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {4'd0, res_pos_q, res_second_q, res_first_q};
            m_axis_tuser  <= res_found_q;
            state_q       <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after taking a word");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> div_d_q != 17'd0)
    else $error("divider started with zero divisor");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < div_d_q)
    else $error("divider remainder out of range");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
    else $error("result word raised outside the finish state");

endmodule
